@@ hw/rtl/mmsd_pkg.sv @@
// Package for the multiplexed meter scan decoder.
// Holds the beat layouts, field widths, event codes and display constants.
// No dependencies; every module of the decoder imports it.
package mmsd_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [3:0] BLANK_DIGIT = 4'hf;
    localparam logic [2:0] POINT_BASE  = 3'd5;

    // Event source carried on s_tuser
    typedef enum logic {
        OP_STROBE0 = 1'b0,
        OP_DIGIT   = 1'b1
    } op_t;

    // One decoded input event
    typedef struct packed {
        op_t        op;
        logic       strobe0_line;
        logic [3:0] strobe_lines;
        logic [3:0] data_nibble;
        logic       hv_line;
        logic       dp_line;
    } in_item_t;

    // One finished display frame
    typedef struct packed {
        logic       negative;
        logic       leading_one;
        logic [3:0] digit_one;
        logic [3:0] digit_two;
        logic [3:0] digit_three;
        logic [3:0] digit_four;
        logic [2:0] point_position;
        logic       overrange;
        logic       decibel_mode;
        logic       relative_mode;
        logic       high_voltage;
    } frame_t;

endpackage

@@ hw/rtl/mmsd_in_stage.sv @@
// Input register stage of the scan decoder.
// Unpacks the slave beat into an event record; depends on mmsd_pkg.
module mmsd_in_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mmsd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           advance,
    output logic                           item_valid,
    output mmsd_pkg::in_item_t             item
);
    import mmsd_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;
    in_item_t item_next;

    // Take a new beat when the stage is empty or its event moves on
    assign s_tready = !valid_reg || advance;

    // Unpack the beat fields
    always_comb
    begin
        item_next.op           = op_t'(s_tuser);
        item_next.strobe0_line = s_tdata[0];
        item_next.strobe_lines = s_tdata[4:1];
        item_next.data_nibble  = s_tdata[8:5];
        item_next.hv_line      = s_tdata[9];
        item_next.dp_line      = s_tdata[10];
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/mmsd_core.sv @@
// Decoder state and frame assembly of the scan decoder.
// Latches flags and digits per event and builds the frame; depends on mmsd_pkg.
module mmsd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  mmsd_pkg::in_item_t item,
    input  logic               fire,
    output logic               emit,
    output mmsd_pkg::frame_t   frame
);
    import mmsd_pkg::*;

    logic [3:0] digit_reg [4];
    logic [3:0] digit_next [4];
    logic       lead_one_reg, lead_one_next;
    logic       sign_reg, sign_next;
    logic       db_reg, db_next;
    logic       rel_reg, rel_next;
    logic       hv_reg, hv_next;
    logic [2:0] point_reg, point_next;
    logic [2:0] point_upd;
    logic [1:0] pos_idx;
    logic       pos_hit;
    logic       over;

    // Pick the first active strobe, order 1 to 4
    always_comb
    begin
        pos_hit = 1'b1;
        pos_idx = 2'd0;
        if (item.strobe_lines[3])
        begin
            pos_idx = 2'd0;
        end
        else if (item.strobe_lines[2])
        begin
            pos_idx = 2'd1;
        end
        else if (item.strobe_lines[1])
        begin
            pos_idx = 2'd2;
        end
        else if (item.strobe_lines[0])
        begin
            pos_idx = 2'd3;
        end
        else
        begin
            pos_hit = 1'b0;
        end
    end

    // Work out the state after this event
    always_comb
    begin
        digit_next    = digit_reg;
        lead_one_next = lead_one_reg;
        sign_next     = sign_reg;
        db_next       = db_reg;
        rel_next      = rel_reg;
        hv_next       = hv_reg;
        point_upd     = point_reg;
        emit          = 1'b0;
        case (item.op)
            OP_STROBE0:
            begin
                if (item.strobe0_line)
                begin
                    lead_one_next = item.data_nibble[0];
                    db_next       = item.data_nibble[1];
                    sign_next     = item.data_nibble[3] && !item.data_nibble[2];
                    hv_next       = item.hv_line;
                    rel_next      = item.dp_line;
                end
            end
            OP_DIGIT:
            begin
                if (pos_hit)
                begin
                    digit_next[pos_idx] = item.data_nibble;
                    if (item.dp_line)
                    begin
                        point_upd = POINT_BASE - 3'd1 - {1'b0, pos_idx};
                    end
                    emit = (pos_idx == 2'd3);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // The last digit closes the frame and drops the point
        point_next = emit ? 3'd0 : point_upd;
    end

    // Build the frame from the updated state
    always_comb
    begin
        over = !lead_one_next &&
               digit_next[0] == BLANK_DIGIT && digit_next[1] == BLANK_DIGIT &&
               digit_next[2] == BLANK_DIGIT && digit_next[3] == BLANK_DIGIT;
        frame.negative       = sign_next;
        frame.leading_one    = lead_one_next;
        frame.digit_one      = digit_next[0];
        frame.digit_two      = digit_next[1];
        frame.digit_three    = digit_next[2];
        frame.digit_four     = digit_next[3];
        frame.point_position = over ? 3'd0 : point_upd;
        frame.overrange      = over;
        frame.decibel_mode   = db_next;
        frame.relative_mode  = rel_next;
        frame.high_voltage   = hv_next;
    end

    // Hold the decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
            lead_one_reg <= 1'b0;
            sign_reg     <= 1'b0;
            db_reg       <= 1'b0;
            rel_reg      <= 1'b0;
            hv_reg       <= 1'b0;
            point_reg    <= 3'd0;
        end
        else if (fire)
        begin
            digit_reg    <= digit_next;
            lead_one_reg <= lead_one_next;
            sign_reg     <= sign_next;
            db_reg       <= db_next;
            rel_reg      <= rel_next;
            hv_reg       <= hv_next;
            point_reg    <= point_next;
        end
    end

    // A closed frame always leaves the point cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> point_reg == 3'd0)
        else $error("point not cleared after frame");

    // Overrange frames carry no point
    assert property (@(posedge clk) disable iff (!rst_n)
        frame.overrange |-> frame.point_position == 3'd0)
        else $error("overrange frame with point");

    // Only a strobe-4 digit event closes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> item.op == OP_DIGIT && item.strobe_lines == 4'b0001)
        else $error("frame from wrong event");

endmodule

@@ hw/rtl/mmsd_out_stage.sv @@
// Result register stage of the scan decoder.
// Holds one frame for the master side and packs its beat; depends on mmsd_pkg.
module mmsd_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  mmsd_pkg::frame_t               frame,
    output logic                           free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mmsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import mmsd_pkg::*;

    logic   valid_reg;
    frame_t frame_reg;

    // Room for a new frame when empty or the current beat leaves now
    assign free = !valid_reg || m_tready;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Capture the frame
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            frame_reg <= frame;
        end
    end

    // Pack the beat, lowest field first
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0,
                       frame_reg.high_voltage,
                       frame_reg.relative_mode,
                       frame_reg.decibel_mode,
                       frame_reg.overrange,
                       frame_reg.point_position,
                       frame_reg.digit_four,
                       frame_reg.digit_three,
                       frame_reg.digit_two,
                       frame_reg.digit_one,
                       frame_reg.leading_one,
                       frame_reg.negative};

endmodule

@@ hw/rtl/multiplexed_meter_scan_decoder.sv @@
// Top level of the multiplexed meter scan decoder.
// Ties the input stage, decoder core and result stage; depends on mmsd_pkg.
//
// Follows the strobe scan of a 4 1/2 digit meter display. Each slave beat is
// one strobe-line change: a strobe-0 beat with the line high latches the
// leading one and the sign, dB, HV and relative flags; a strobe 1-4 beat
// stores the digit of the first active strobe and, with the point line set,
// records the point position. The strobe-4 beat sends one frame on the master
// side and clears the point. Overrange is flagged when there is no leading
// one and all four digits are blank, and then the point reads as zero.
// Each beat passes the input register and then updates the decoder state;
// a beat is accepted every cycle as long as the single result register can
// take the frame. A strobe-4 beat passes two registers: its frame moves from
// the input register into the result register once that register is free,
// and is then offered on the master side. No clearing pass after reset.
module multiplexed_meter_scan_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // strobe0_line[0], strobe_lines[4:1], data_nibble[8:5], hv_line[9],
    // dp_line[10], zero fill [15:11]
    input  logic [mmsd_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]: 0 strobe 0 changed, 1 strobe 1-4 changed
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // negative[0], leading_one[1], digit_one[5:2], digit_two[9:6],
    // digit_three[13:10], digit_four[17:14], point_position[20:18],
    // overrange[21], decibel_mode[22], relative_mode[23],
    // high_voltage[24], zero fill [31:25]
    output logic [mmsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import mmsd_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     emit;
    frame_t   frame;
    logic     out_free;
    logic     advance;

    // Move the held beat on unless its frame has nowhere to go
    assign advance = item_valid && (!emit || out_free);

    mmsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mmsd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .fire  (advance),
        .emit  (emit),
        .frame (frame)
    );

    mmsd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && emit),
        .frame    (frame),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A frame that moves on shows up on the master side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> m_tvalid)
        else $error("frame lost between core and result stage");

    // A stalled full result stage blocks a frame-closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && emit && m_tvalid && !m_tready |-> !advance && !s_tready)
        else $error("frame-closing beat moved into a full result stage");

    // An empty input stage always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_tready)
        else $error("empty input stage not ready");

endmodule

@@ bench/scan_frame_monitor.sv @@
`timescale 1ns / 100ps
// Frame monitor for the multiplexed meter scan decoder testbench.
// Watches both stream channels, predicts each frame and compares it by field.
// Depends on mmsd_pkg for the event codes, frame layout and display constants.
module scan_frame_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // strobe0_line[0], strobe_lines[4:1], data_nibble[8:5], hv_line[9],
    // dp_line[10], zero fill [15:11]
    input  logic [mmsd_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // negative[0], leading_one[1], digit_one[5:2], digit_two[9:6],
    // digit_three[13:10], digit_four[17:14], point_position[20:18],
    // overrange[21], decibel_mode[22], relative_mode[23],
    // high_voltage[24], zero fill [31:25]
    input  logic [mmsd_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             frames_pending
);
    import mmsd_pkg::*;

    localparam int MAX_REPORTS = 20;

    // Shadow copy of the decoder state
    logic [3:0] digit_shadow [4];
    logic       lead_shadow;
    logic       sign_shadow;
    logic       db_shadow;
    logic       rel_shadow;
    logic       hv_shadow;
    logic [2:0] point_shadow;

    frame_t     frames_due [$];
    int         mismatches = 0;
    int         due_count  = 0;
    in_item_t   seen_event;
    frame_t     seen_frame;
    frame_t     want_frame;

    assign fail_count     = mismatches;
    assign frames_pending = due_count;

    // Count a failure and report it while the report budget lasts
    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t frame field %s: expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // Advance the shadow state by one event; queue a frame on strobe 4
    task automatic scan_event(input in_item_t ev);
        int     pos;
        frame_t f;
        logic   over;
        pos = 0;
        if (ev.op == OP_STROBE0)
        begin
            if (ev.strobe0_line)
            begin
                lead_shadow = ev.data_nibble[0];
                db_shadow   = ev.data_nibble[1];
                sign_shadow = ev.data_nibble[3] & ~ev.data_nibble[2];
                hv_shadow   = ev.hv_line;
                rel_shadow  = ev.dp_line;
            end
        end
        else
        begin
            // First active strobe wins, in the order 1 to 4
            if (ev.strobe_lines[3])
                pos = 1;
            else if (ev.strobe_lines[2])
                pos = 2;
            else if (ev.strobe_lines[1])
                pos = 3;
            else if (ev.strobe_lines[0])
                pos = 4;
            if (pos != 0)
            begin
                digit_shadow[pos - 1] = ev.data_nibble;
                if (ev.dp_line)
                    point_shadow = POINT_BASE - 3'(pos);
                if (pos == 4)
                begin
                    over = !lead_shadow
                        && digit_shadow[0] == BLANK_DIGIT
                        && digit_shadow[1] == BLANK_DIGIT
                        && digit_shadow[2] == BLANK_DIGIT
                        && digit_shadow[3] == BLANK_DIGIT;
                    f.negative       = sign_shadow;
                    f.leading_one    = lead_shadow;
                    f.digit_one      = digit_shadow[0];
                    f.digit_two      = digit_shadow[1];
                    f.digit_three    = digit_shadow[2];
                    f.digit_four     = digit_shadow[3];
                    f.point_position = over ? 3'd0 : point_shadow;
                    f.overrange      = over;
                    f.decibel_mode   = db_shadow;
                    f.relative_mode  = rel_shadow;
                    f.high_voltage   = hv_shadow;
                    frames_due.push_back(f);
                    point_shadow = 3'd0;
                end
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                digit_shadow[i] = 4'd0;
            lead_shadow  = 1'b0;
            sign_shadow  = 1'b0;
            db_shadow    = 1'b0;
            rel_shadow   = 1'b0;
            hv_shadow    = 1'b0;
            point_shadow = 3'd0;
            frames_due.delete();
            due_count = 0;
        end
        else
        begin
            // Compare an output beat with the oldest frame due
            if (m_tvalid && m_tready)
            begin
                seen_frame.negative       = m_tdata[0];
                seen_frame.leading_one    = m_tdata[1];
                seen_frame.digit_one      = m_tdata[5:2];
                seen_frame.digit_two      = m_tdata[9:6];
                seen_frame.digit_three    = m_tdata[13:10];
                seen_frame.digit_four     = m_tdata[17:14];
                seen_frame.point_position = m_tdata[20:18];
                seen_frame.overrange      = m_tdata[21];
                seen_frame.decibel_mode   = m_tdata[22];
                seen_frame.relative_mode  = m_tdata[23];
                seen_frame.high_voltage   = m_tdata[24];
                if (frames_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t unexpected frame: expected none, actual %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want_frame = frames_due.pop_front();
                    check_field("negative", 4'(want_frame.negative),
                                4'(seen_frame.negative));
                    check_field("leading_one", 4'(want_frame.leading_one),
                                4'(seen_frame.leading_one));
                    check_field("digit_one", want_frame.digit_one,
                                seen_frame.digit_one);
                    check_field("digit_two", want_frame.digit_two,
                                seen_frame.digit_two);
                    check_field("digit_three", want_frame.digit_three,
                                seen_frame.digit_three);
                    check_field("digit_four", want_frame.digit_four,
                                seen_frame.digit_four);
                    check_field("point_position", 4'(want_frame.point_position),
                                4'(seen_frame.point_position));
                    check_field("overrange", 4'(want_frame.overrange),
                                4'(seen_frame.overrange));
                    check_field("decibel_mode", 4'(want_frame.decibel_mode),
                                4'(seen_frame.decibel_mode));
                    check_field("relative_mode", 4'(want_frame.relative_mode),
                                4'(seen_frame.relative_mode));
                    check_field("high_voltage", 4'(want_frame.high_voltage),
                                4'(seen_frame.high_voltage));
                end
            end

            // Feed each accepted input beat to the predictor
            if (s_tvalid && s_tready)
            begin
                seen_event.op           = op_t'(s_tuser);
                seen_event.strobe0_line = s_tdata[0];
                seen_event.strobe_lines = s_tdata[4:1];
                seen_event.data_nibble  = s_tdata[8:5];
                seen_event.hv_line      = s_tdata[9];
                seen_event.dp_line      = s_tdata[10];
                scan_event(seen_event);
            end
            due_count = frames_due.size();
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Top of the multiplexed meter scan decoder testbench.
// Drives scan events and output back-pressure; scan_frame_monitor checks.
// Depends on mmsd_pkg, multiplexed_meter_scan_decoder and scan_frame_monitor.
module tb;
    import mmsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LIVE_TARGET = 1500;
    localparam int CALM_FROM   = 1250;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   frames_pending;

    int                   live_items = 0;
    bit                   calm       = 1'b0;
    bit                   hold_done  = 1'b0;

    multiplexed_meter_scan_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scan_frame_monitor u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give up if the run stalls
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("multiplexed_meter_scan_decoder: mismatch");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none near the end
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!hold_done && live_items >= HOLD_AT)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                m_tready  = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_tready = 1'b1;
            end
            else
                m_tready = 1'b1;
        end
    end

    // Offer one event beat and hold it until accepted
    task automatic drive_event(input op_t op, input logic st0, input logic [3:0] strobes,
                               input logic [3:0] nib, input logic hv, input logic dp);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {{(S_TDATA_W - 11){1'b0}}, dp, hv, nib, strobes, st0};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_DIGIT ? strobes != 4'd0 : st0)
            live_items++;
        @(negedge clk);
    endtask

    // Any event at all, mostly junk
    task automatic drive_noise();
        drive_event(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // One display scan: strobe 0 then strobes 1 to 4, now and then broken
    task automatic run_scan();
        logic       lead;
        logic       blanked;
        logic [3:0] digits [4];
        logic [3:0] strobe_bit;
        logic [3:0] extra;
        blanked = ($urandom_range(0, 7) == 0);
        lead    = blanked ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
        for (int p = 0; p < 4; p++)
            digits[p] = blanked ? BLANK_DIGIT : 4'($urandom_range(0, 15));
        // Falling strobe 0 edge, which must be ignored
        if ($urandom_range(0, 3) == 0)
            drive_event(OP_STROBE0, 1'b0, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        drive_event(OP_STROBE0, 1'b1, 4'($urandom_range(0, 15)),
                    {2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), lead},
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        for (int p = 0; p < 4; p++)
        begin
            // Drop a digit now and then to break the scan
            if (p < 3 && $urandom_range(0, 15) == 0)
                continue;
            if ($urandom_range(0, 9) == 0)
                drive_event(OP_DIGIT, 1'($urandom_range(0, 1)), 4'd0,
                            4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            strobe_bit = 4'h8 >> p;
            extra = ($urandom_range(0, 3) == 0) ?
                    (4'($urandom_range(0, 15)) & (strobe_bit - 4'd1)) : 4'd0;
            drive_event(OP_DIGIT, 1'($urandom_range(0, 1)), strobe_bit | extra, digits[p],
                        1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_STROBE0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Strobe 0 low is ignored; frame straight from reset state
        drive_event(OP_STROBE0, 1'b0, 4'hf, 4'hf, 1'b1, 1'b1);
        drive_event(OP_DIGIT,   1'b1, 4'h1, 4'h7, 1'b1, 1'b1);
        // Minus clear, plus set: negative, with leading one, HV and relative
        drive_event(OP_STROBE0, 1'b1, 4'h0, 4'b1001, 1'b1, 1'b1);
        drive_event(OP_DIGIT,   1'b0, 4'h8, 4'h0, 1'b0, 1'b0);
        drive_event(OP_DIGIT,   1'b0, 4'h4, 4'h9, 1'b0, 1'b1);
        // No strobe active
        drive_event(OP_DIGIT,   1'b0, 4'h0, 4'h5, 1'b1, 1'b1);
        drive_event(OP_DIGIT,   1'b0, 4'h2, 4'hf, 1'b0, 1'b0);
        drive_event(OP_DIGIT,   1'b0, 4'h1, 4'h3, 1'b0, 1'b0);
        // Point was cleared by the previous frame
        drive_event(OP_DIGIT,   1'b0, 4'h1, 4'h3, 1'b0, 1'b0);
        // Plus and minus both set, dB, no leading one; several strobes at once
        drive_event(OP_STROBE0, 1'b1, 4'hf, 4'b1110, 1'b0, 1'b0);
        drive_event(OP_DIGIT,   1'b1, 4'hf, 4'hf, 1'b0, 1'b1);
        drive_event(OP_DIGIT,   1'b1, 4'h7, 4'hf, 1'b0, 1'b0);
        drive_event(OP_DIGIT,   1'b1, 4'h3, 4'hf, 1'b0, 1'b0);
        // All blank, no leading one: overrange with the point forced off
        drive_event(OP_DIGIT,   1'b1, 4'h1, 4'hf, 1'b0, 1'b0);
        // Low strobe 0 leaves the flags alone
        drive_event(OP_STROBE0, 1'b0, 4'h0, 4'b0001, 1'b1, 1'b1);
        drive_event(OP_DIGIT,   1'b0, 4'h1, 4'h0, 1'b0, 1'b0);
        // All flags clear, zero digits, point at position two
        drive_event(OP_STROBE0, 1'b1, 4'h0, 4'h0, 1'b0, 1'b0);
        drive_event(OP_DIGIT,   1'b0, 4'h8, 4'h0, 1'b1, 1'b0);
        drive_event(OP_DIGIT,   1'b0, 4'h4, 4'h0, 1'b0, 1'b0);
        drive_event(OP_DIGIT,   1'b0, 4'h2, 4'h0, 1'b0, 1'b1);
        drive_event(OP_DIGIT,   1'b0, 4'h1, 4'h0, 1'b0, 1'b0);

        // Random scans mixed with noise; no idling in the last stretch
        while (live_items < LIVE_TARGET)
        begin
            calm = (live_items >= CALM_FROM);
            if ($urandom_range(0, 4) == 0)
                drive_noise();
            else
                run_scan();
        end
        s_tvalid = 1'b0;

        // Drain the result side, then watch for strays
        wait (frames_pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("multiplexed_meter_scan_decoder: match");
        else
            $display("multiplexed_meter_scan_decoder: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mmsd_pkg.sv
hw/rtl/mmsd_in_stage.sv
hw/rtl/mmsd_core.sv
hw/rtl/mmsd_out_stage.sv
hw/rtl/multiplexed_meter_scan_decoder.sv
bench/scan_frame_monitor.sv
bench/tb.sv
